// ===== hdl/i2cm_pkg.sv =====
// Package for the I2C master byte engine: payload structs, command codes
// and shared constants. No dependencies.
package i2cm_pkg;

  localparam int BYTE_BITS = 8;
  localparam int CNT_W     = 4;
  localparam int PHASE_W   = 3;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [BYTE_BITS-1:0] write_data;
    logic                 send_ack;
    logic                 sda_sample;
  } in_item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] read_data;
    logic                 ack_missing;
  } out_item_t;

  // classified tick as handed from the front end to the sequencer
  typedef struct packed {
    cmd_t                 cmd;
    logic [BYTE_BITS-1:0] write_data;
    logic                 send_ack;
    logic                 sda_sample;
  } tick_t;

endpackage

// ===== hdl/i2cm_fifo.sv =====
// Two-entry register FIFO of generic width.
// No package dependencies.
module i2cm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/i2cm_front.sv =====
// Front end: takes input items, maps the opcode to a command and queues
// the classified tick. Depends on i2cm_pkg and i2cm_fifo.
module i2cm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cm_pkg::in_item_t in_item,
  output logic               full,
  output logic               tick_valid,
  output i2cm_pkg::tick_t    tick,
  input  logic               tick_pop
);
  import i2cm_pkg::*;

  tick_t cls;
  logic  q_empty;

  // reserved opcodes behave like no command
  always_comb begin
    cls.write_data = in_item.write_data;
    cls.send_ack   = in_item.send_ack;
    cls.sda_sample = in_item.sda_sample;
    unique case (in_item.opcode)
      CMD_START: cls.cmd = CMD_START;
      CMD_STOP:  cls.cmd = CMD_STOP;
      CMD_WRITE: cls.cmd = CMD_WRITE;
      CMD_READ:  cls.cmd = CMD_READ;
      default:   cls.cmd = CMD_NONE;
    endcase
  end

  i2cm_fifo #(.WIDTH($bits(tick_t))) u_tick_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (full),
    .pop       (tick_pop),
    .pop_data  (tick),
    .empty     (q_empty)
  );

  assign tick_valid = !q_empty;

endmodule

// ===== hdl/i2cm_back.sv =====
// Sequencer: runs start, stop, write and read commands one tick at a time
// and emits one result per tick. Depends on i2cm_pkg.
module i2cm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                tick_valid,
  input  i2cm_pkg::tick_t     tick,
  output logic                tick_pop,
  output logic                res_push,
  output i2cm_pkg::out_item_t res,
  input  logic                res_full
);
  import i2cm_pkg::*;

  cmd_t                 active_cmd_r, cmd_nxt, ld_cmd;
  logic [PHASE_W-1:0]   phase_r, phase_nxt, ld_phase;
  logic [CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt, ld_bit_cnt, bit_cnt_inc;
  logic [BYTE_BITS-1:0] shift_r, shift_nxt, ld_shift;
  logic [7:0]           wait_r, wait_nxt, ld_wait;
  logic                 scl_r, scl_nxt, sda_r, sda_nxt;
  logic                 nack_r, nack_nxt, ld_nack;
  logic [7:0]           ack_timeout_r;
  logic                 fire, done, byte_end, timed_out;
  logic [2:0]           bit_pos;

  assign fire     = tick_valid && !res_full;
  assign tick_pop = fire;
  assign res_push = fire;

  // command load when idle
  always_comb begin
    ld_cmd     = active_cmd_r;
    ld_phase   = phase_r;
    ld_bit_cnt = bit_cnt_r;
    ld_wait    = wait_r;
    ld_shift   = shift_r;
    ld_nack    = nack_r;
    if (active_cmd_r == CMD_NONE && tick.cmd != CMD_NONE) begin
      ld_cmd     = tick.cmd;
      ld_phase   = '0;
      ld_bit_cnt = '0;
      ld_wait    = '0;
      if (tick.cmd == CMD_WRITE) begin
        ld_wait = tick.write_data;
        ld_nack = 1'b0;
      end else if (tick.cmd == CMD_READ) begin
        ld_wait  = {7'd0, tick.send_ack};
        ld_shift = '0;
      end
    end
  end

  assign bit_cnt_inc = ld_bit_cnt + CNT_W'(1);
  assign byte_end    = (bit_cnt_inc >= CNT_W'(BYTE_BITS));
  assign timed_out   = (ld_wait >= ack_timeout_r);
  assign bit_pos     = 3'(BYTE_BITS - 1) - ld_bit_cnt[2:0];

  // next state
  always_comb begin
    cmd_nxt   = ld_cmd;
    phase_nxt = ld_phase;
    unique case (ld_cmd)
      CMD_START, CMD_STOP: begin
        if (ld_phase == 3'd0) phase_nxt = 3'd1;
        else if (ld_phase == 3'd1) phase_nxt = 3'd2;
      end
      CMD_WRITE: begin
        unique case (ld_phase)
          3'd0: phase_nxt = 3'd1;
          3'd1: phase_nxt = byte_end ? 3'd2 : 3'd0;
          3'd2: phase_nxt = 3'd3;
          3'd3: phase_nxt = 3'd4;
          3'd4: if (tick.sda_sample && timed_out) phase_nxt = 3'd5;
          3'd5: phase_nxt = 3'd6;
          default: phase_nxt = ld_phase;
        endcase
      end
      CMD_READ: begin
        unique case (ld_phase)
          3'd0: phase_nxt = 3'd1;
          3'd1: phase_nxt = byte_end ? 3'd2 : 3'd0;
          3'd2: phase_nxt = 3'd3;
          3'd3: phase_nxt = 3'd4;
          3'd4: if (!sda_r) phase_nxt = 3'd5;
          default: phase_nxt = ld_phase;
        endcase
      end
      default: cmd_nxt = CMD_NONE;
    endcase
    if (done) begin
      cmd_nxt   = CMD_NONE;
      phase_nxt = '0;
    end
  end

  // line drives and datapath
  always_comb begin
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    bit_cnt_nxt = ld_bit_cnt;
    wait_nxt    = ld_wait;
    shift_nxt   = ld_shift;
    nack_nxt    = ld_nack;
    done        = 1'b0;
    unique case (ld_cmd)
      CMD_START: begin
        if (ld_phase == 3'd0) begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end else if (ld_phase == 3'd1) begin
          sda_nxt = 1'b0;
        end else begin
          scl_nxt = 1'b0;
          done    = 1'b1;
        end
      end
      CMD_STOP: begin
        if (ld_phase == 3'd0) begin
          sda_nxt = 1'b0;
        end else if (ld_phase == 3'd1) begin
          scl_nxt = 1'b1;
        end else begin
          sda_nxt = 1'b1;
          done    = 1'b1;
        end
      end
      CMD_WRITE: begin
        unique case (ld_phase)
          3'd0: begin
            scl_nxt = 1'b0;
            sda_nxt = ld_wait[bit_pos];
          end
          3'd1: begin
            scl_nxt     = 1'b1;
            bit_cnt_nxt = bit_cnt_inc;
          end
          3'd2: begin
            scl_nxt  = 1'b0;
            sda_nxt  = 1'b1;
            wait_nxt = '0;
          end
          3'd3: scl_nxt = 1'b1;
          3'd4: begin
            if (!tick.sda_sample) begin
              scl_nxt = 1'b0;
              done    = 1'b1;
            end else if (timed_out) begin
              nack_nxt = 1'b1;
              scl_nxt  = 1'b0;
              sda_nxt  = 1'b0;
            end else begin
              wait_nxt = ld_wait + 8'd1;
            end
          end
          3'd5: scl_nxt = 1'b1;
          default: begin
            sda_nxt = 1'b1;
            done    = 1'b1;
          end
        endcase
      end
      CMD_READ: begin
        unique case (ld_phase)
          3'd0: begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
          end
          3'd1: begin
            shift_nxt   = {ld_shift[BYTE_BITS-2:0], tick.sda_sample};
            scl_nxt     = 1'b0;
            bit_cnt_nxt = bit_cnt_inc;
          end
          3'd2: sda_nxt = (ld_wait == 8'd0);
          3'd3: scl_nxt = 1'b1;
          3'd4: begin
            scl_nxt = 1'b0;
            done    = sda_r;
          end
          default: begin
            sda_nxt = 1'b1;
            done    = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_level   = sda_nxt;
    res.busy_res    = (cmd_nxt != CMD_NONE);
    res.done_res    = done;
    res.read_data   = shift_nxt;
    res.ack_missing = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      ack_timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cmd_r <= CMD_NONE;
      phase_r      <= '0;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      wait_r       <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      nack_r       <= 1'b0;
    end else if (fire) begin
      active_cmd_r <= cmd_nxt;
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      wait_r       <= wait_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      nack_r       <= nack_nxt;
    end
  end

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// I2C master byte engine, one input item per bus bit-delay tick.
// A result reaches the result ports once its accepted item has passed the tick
// queue and then the sequencer into the result queue; it can be popped from there.
// Throughput: one item per cycle, with one sequencer update per accepted tick;
// full/empty only stall.
// Reset (rst_n low, synchronous): queues empty, engine idle, lines released,
// ack_timeout back to 250.
module i2c_master_byte_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  i2cm_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);
  import i2cm_pkg::*;

  logic      tick_valid, tick_pop, res_push, res_full;
  tick_t     tick;
  out_item_t res;

  i2cm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_item    (in_item),
    .full       (full),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_pop   (tick_pop)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_pop   (tick_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  i2cm_fifo #(.WIDTH($bits(out_item_t))) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (out_item),
    .empty     (empty)
  );

endmodule

// ===== hdl/i2cm_checker.sv =====
// Port-level checks for the I2C master byte engine, bound to the top level.
// Depends on i2cm_pkg.
module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input i2cm_pkg::out_item_t out_item
);
  import i2cm_pkg::*;

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // the last tick of a command never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.done_res |-> !out_item.busy_res)
    else $error("done result still busy");

  // a finishing result with SCL released also has SDA released, as after a stop or an ack timeout
  a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.done_res && out_item.scl_level |-> out_item.sda_level)
    else $error("done with scl released but sda low");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

// ===== tb/sv/i2c_master_byte_engine_chk.sv =====
// Checker for the I2C master byte engine: tracks accepted ticks and config writes,
// predicts each result and compares it with what the block pops out.
// Depends on i2cm_pkg.
module i2c_master_byte_engine_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  i2cm_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  i2cm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int MAX_REPORTS = 30;

  // engine copy
  cmd_t                 cur_cmd;
  logic [PHASE_W-1:0]   step;
  logic [CNT_W-1:0]     nbits;
  logic [BYTE_BITS-1:0] rx_byte;
  logic [7:0]           wcnt;      // write byte, latched ack flag or poll count
  logic                 scl_q;
  logic                 sda_q;
  logic                 nack_q;
  logic [7:0]           ack_tmo = ACK_TIMEOUT_RST;

  out_item_t line_q[$];
  out_item_t want;
  logic      field_bad;
  int        n_fail = 0;
  int        n_checked = 0;

  assign fail_count = n_fail;
  assign pending    = line_q.size();
  assign checked    = n_checked;

  function automatic void reset_engine();
    cur_cmd = CMD_NONE;
    step    = '0;
    nbits   = '0;
    rx_byte = '0;
    wcnt    = '0;
    scl_q   = 1'b1;
    sda_q   = 1'b1;
    nack_q  = 1'b0;
    ack_tmo = ACK_TIMEOUT_RST;
  endfunction

  // one bus tick; returns the line state and flags after it
  function automatic out_item_t engine_tick(input in_item_t it);
    out_item_t    r;
    logic         fin;
    logic [2:0]   pos;
    fin = 1'b0;
    if (cur_cmd == CMD_NONE) begin
      case (it.opcode)
        CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: begin
          cur_cmd = cmd_t'(it.opcode);
          step    = '0;
          nbits   = '0;
          wcnt    = '0;
          if (it.opcode == CMD_WRITE) begin
            wcnt   = it.write_data;
            nack_q = 1'b0;
          end else if (it.opcode == CMD_READ) begin
            wcnt    = {7'd0, it.send_ack};
            rx_byte = '0;
          end
        end
        default: ;
      endcase
    end

    case (cur_cmd)
      CMD_START: begin
        if (step == 3'd0) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          step  = 3'd1;
        end else if (step == 3'd1) begin
          sda_q = 1'b0;
          step  = 3'd2;
        end else begin
          scl_q = 1'b0;
          fin   = 1'b1;
        end
      end
      CMD_STOP: begin
        if (step == 3'd0) begin
          sda_q = 1'b0;
          step  = 3'd1;
        end else if (step == 3'd1) begin
          scl_q = 1'b1;
          step  = 3'd2;
        end else begin
          sda_q = 1'b1;
          fin   = 1'b1;
        end
      end
      CMD_WRITE: begin
        case (step)
          3'd0: begin
            pos   = 3'd7 - nbits[2:0];
            scl_q = 1'b0;
            sda_q = wcnt[pos];
            step  = 3'd1;
          end
          3'd1: begin
            scl_q = 1'b1;
            nbits = nbits + 1'b1;
            step  = (nbits >= BYTE_BITS) ? 3'd2 : 3'd0;
          end
          3'd2: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            wcnt  = '0;
            step  = 3'd3;
          end
          3'd3: begin
            scl_q = 1'b1;
            step  = 3'd4;
          end
          3'd4: begin
            if (!it.sda_sample) begin
              scl_q = 1'b0;
              fin   = 1'b1;
            end else if (wcnt >= ack_tmo) begin
              // no ack: flag it and run a stop
              nack_q = 1'b1;
              scl_q  = 1'b0;
              sda_q  = 1'b0;
              step   = 3'd5;
            end else begin
              wcnt = wcnt + 1'b1;
            end
          end
          3'd5: begin
            scl_q = 1'b1;
            step  = 3'd6;
          end
          default: begin
            sda_q = 1'b1;
            fin   = 1'b1;
          end
        endcase
      end
      CMD_READ: begin
        case (step)
          3'd0: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            step  = 3'd1;
          end
          3'd1: begin
            rx_byte = {rx_byte[BYTE_BITS-2:0], it.sda_sample};
            scl_q   = 1'b0;
            nbits   = nbits + 1'b1;
            step    = (nbits >= BYTE_BITS) ? 3'd2 : 3'd0;
          end
          3'd2: begin
            sda_q = (wcnt != 8'd0) ? 1'b0 : 1'b1;
            step  = 3'd3;
          end
          3'd3: begin
            scl_q = 1'b1;
            step  = 3'd4;
          end
          3'd4: begin
            scl_q = 1'b0;
            if (!sda_q) step = 3'd5;
            else fin = 1'b1;
          end
          default: begin
            sda_q = 1'b1;
            fin   = 1'b1;
          end
        endcase
      end
      default: cur_cmd = CMD_NONE;
    endcase

    if (fin) begin
      cur_cmd = CMD_NONE;
      step    = '0;
    end

    r.scl_level   = scl_q;
    r.sda_level   = sda_q;
    r.busy_res    = (cur_cmd != CMD_NONE);
    r.done_res    = fin;
    r.read_data   = rx_byte;
    r.ack_missing = nack_q;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      field_bad = 1'b1;
      if (n_fail < MAX_REPORTS)
        $error("%s: expected %0h, got %0h", fname, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_engine();
      line_q.delete();
    end else begin
      if (cfg_we) ack_tmo = cfg_data;
      if (pop && !empty) begin
        if (line_q.size() == 0) begin
          if (n_fail < MAX_REPORTS) $error("result popped with no transaction pending");
          n_fail++;
        end else begin
          want      = line_q.pop_front();
          field_bad = 1'b0;
          check_field("scl_level", want.scl_level, out_item.scl_level);
          check_field("sda_level", want.sda_level, out_item.sda_level);
          check_field("busy_res", want.busy_res, out_item.busy_res);
          check_field("done_res", want.done_res, out_item.done_res);
          check_field("read_data", want.read_data, out_item.read_data);
          check_field("ack_missing", want.ack_missing, out_item.ack_missing);
          if (field_bad) n_fail++;
          n_checked++;
        end
      end
      if (push && !full) line_q.push_back(engine_tick(in_item));
    end
  end

endmodule

// ===== tb/sv/i2c_master_byte_engine_tb.sv =====
// Top of the I2C master byte engine testbench: clock, reset, tick stimulus,
// result drain and verdict. Depends on i2cm_pkg, the engine and its checker.
module i2c_master_byte_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       empty;
  logic       pop;
  out_item_t  out_item;
  logic       cfg_we;
  logic [7:0] cfg_data;

  int fail_count;
  int pending;
  int checked;

  int send_idle = 31;
  int recv_idle = 67;
  int hold_req  = 0;
  int items_sent = 0;
  int cur_tmo = ACK_TIMEOUT_RST;
  int n_start = 0, n_stop = 0, n_write = 0, n_read = 0, n_tmo = 0;

  always #10 clk = ~clk;

  i2c_master_byte_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  i2c_master_byte_engine_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  function automatic in_item_t mk_tick(input logic [2:0] op, input logic [7:0] d,
                                       input logic ack, input logic sda);
    in_item_t t;
    t.opcode     = op;
    t.write_data = d;
    t.send_ack   = ack;
    t.sda_sample = sda;
    return t;
  endfunction

  // entered and left at a falling edge; push stays high between back-to-back ticks
  task automatic send_tick(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // tick while a command runs; now and then carries a command that must be ignored
  task automatic busy_tick(input logic sda);
    logic [2:0] op;
    op = CMD_NONE;
    if ($urandom_range(0, 3) == 0) op = 3'($urandom_range(0, 7));
    send_tick(mk_tick(op, 8'($urandom), 1'($urandom), sda));
  endtask

  task automatic noise_tick(input logic [2:0] op);
    send_tick(mk_tick(op, 8'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  task automatic do_bus_cond(input cmd_t cmd);
    noise_tick(cmd);
    repeat (2) busy_tick(1'($urandom));
    if (cmd == CMD_START) n_start++;
    else n_stop++;
  endtask

  // highs: SDA-high poll samples before the slave pulls SDA low
  task automatic do_write(input logic [7:0] data, input int highs);
    send_tick(mk_tick(CMD_WRITE, data, 1'($urandom), 1'($urandom)));
    repeat (17) busy_tick(1'($urandom));
    if (highs <= cur_tmo) begin
      repeat (highs) busy_tick(1'b1);
      busy_tick(1'b0);
    end else begin
      repeat (cur_tmo + 1) busy_tick(1'b1);
      repeat (2) busy_tick(1'($urandom));
      n_tmo++;
    end
    n_write++;
  endtask

  task automatic do_read(input logic ack);
    send_tick(mk_tick(CMD_READ, 8'($urandom), ack, 1'($urandom)));
    repeat (ack ? 19 : 18) busy_tick(1'($urandom));
    n_read++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_timeout(input int v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= 8'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_tmo = v;
  endtask

  task automatic random_phase(input int budget, input int s_idle, input int r_idle);
    int stop_at;
    int pick;
    int hi;
    send_idle = s_idle;
    recv_idle = r_idle;
    stop_at   = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) do_bus_cond(CMD_START);
      else if (pick < 24) do_bus_cond(CMD_STOP);
      else if (pick < 56) begin
        hi = (cur_tmo < 3) ? cur_tmo : 3;
        if ($urandom_range(0, 3) == 0) do_write(8'($urandom), cur_tmo + 1);
        else do_write(8'($urandom), $urandom_range(0, hi));
      end else if (pick < 84) do_read(1'($urandom));
      else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) noise_tick(3'($urandom_range(0, 7)));
      end else begin
        // command cut short; SDA held low afterwards lets any command finish
        noise_tick(3'($urandom_range(CMD_START, CMD_READ)));
        repeat ($urandom_range(0, 10)) busy_tick(1'($urandom));
        repeat (24) send_tick(mk_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'b0));
      end
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int held;
    int seen_req;
    held     = 0;
    seen_req = 0;
    pop      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        held     = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    push     = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed, timeout at its reset value
    noise_tick(CMD_NONE);
    noise_tick(3'd5);
    noise_tick(3'd6);
    noise_tick(3'd7);
    do_bus_cond(CMD_START);
    do_write(8'hFF, 0);
    do_write(8'h00, 3);
    do_write(8'hA5, cur_tmo);       // ack on the last tolerated sample
    do_read(1'b1);
    do_read(1'b0);
    do_write(8'h5A, cur_tmo + 1);   // no ack
    do_bus_cond(CMD_STOP);
    set_timeout(0);
    do_write(8'h81, 0);
    do_write(8'h7E, 1);             // first high sample already times out
    set_timeout(255);
    do_write(8'hC3, 256);
    set_timeout(1);
    do_write(8'h3C, 1);
    do_write(8'h99, 2);

    set_timeout($urandom_range(1, 6));
    random_phase(160, 31, 67);
    set_timeout($urandom_range(2, 12));
    random_phase(100, 67, 31);
    drain();
    random_phase(80, 67, 31);
    set_timeout($urandom_range(0, 8));
    hold_req++;
    random_phase(120, 0, 0);
    drain();
    repeat (10) @(negedge clk);

    $display("Sent %0d ticks, checked %0d results: %0d start, %0d stop, %0d read,",
             items_sent, checked, n_start, n_stop, n_read);
    $display("%0d write (%0d without ack), ack timeout swept from 0 to 255",
             n_write, n_tmo);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
